>>> rtl/lfc_pkg.sv
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types and constants for the LED frame crossfade block.
// ----------------------------------------------------------------------------
package lfc_pkg;

    localparam int IDX_W   = 5;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int STEP_W  = 10;
    localparam int TDATA_W = 32;

    localparam int NUM_PIXELS_DEF = 32;

    localparam logic [STEP_W-1:0] FADE_RESET = 10'd20;

    // tuser codes on the slave side
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // register index of fade_steps
    localparam logic REG_FADE_STEPS = 1'b0;

    // one channel job for the shared multiply/divide unit
    typedef struct packed {
        logic [CH_W-1:0]   from_val;
        logic [CH_W-1:0]   to_val;
        logic [STEP_W-1:0] done_cnt;
        logic [STEP_W-1:0] total_cnt;
    } mix_req_t;

endpackage

>>> rtl/lfc_ram.sv
// ----------------------------------------------------------------------------
// lfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lfc_mix.sv
// ----------------------------------------------------------------------------
// lfc_mix
// Shared channel mixer: from + trunc((to - from) * done / total), a
// multiply then eight restoring divide steps.
// ----------------------------------------------------------------------------
module lfc_mix
    import lfc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  mix_req_t        req,
    output logic            ack,
    output logic [CH_W-1:0] result
);

    localparam int PROD_W = CH_W + STEP_W;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIN} mstate_t;

    mstate_t             state_reg;
    logic                neg_reg;
    logic [CH_W-1:0]     from_reg;
    logic [CH_W-1:0]     mag_reg;
    logic [STEP_W-1:0]   done_reg;
    logic [STEP_W-1:0]   total_reg;
    logic [PROD_W-1:0]   rem_reg;
    logic [PROD_W-1:0]   div_reg;
    logic [CH_W-1:0]     quo_reg;
    logic [2:0]          step_reg;
    logic                ack_reg;
    logic [CH_W-1:0]     result_reg;

    logic                ge;
    logic                to_below;

    assign ge       = (rem_reg >= div_reg);
    assign to_below = (req.to_val < req.from_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            ack_reg   <= 1'b0;
        end else begin
            ack_reg <= (state_reg == M_FIN);
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        from_reg  <= req.from_val;
                        neg_reg   <= to_below;
                        mag_reg   <= to_below ? (req.from_val - req.to_val)
                                              : (req.to_val - req.from_val);
                        done_reg  <= req.done_cnt;
                        total_reg <= req.total_cnt;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL: begin
                    rem_reg   <= {{STEP_W{1'b0}}, mag_reg} * {{CH_W{1'b0}}, done_reg};
                    // quotient fits in 8 bits since done < total
                    div_reg   <= {1'b0, total_reg, {(CH_W-1){1'b0}}};
                    quo_reg   <= '0;
                    step_reg  <= 3'd7;
                    state_reg <= M_DIV;
                end
                M_DIV: begin
                    if (ge) begin
                        rem_reg <= rem_reg - div_reg;
                    end
                    quo_reg  <= {quo_reg[CH_W-2:0], ge};
                    div_reg  <= div_reg >> 1;
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0) begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN: begin
                    result_reg <= neg_reg ? (from_reg - quo_reg) : (from_reg + quo_reg);
                    state_reg  <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign ack    = ack_reg;
    assign result = result_reg;

endmodule

>>> rtl/led_frame_crossfade_top.sv
// ----------------------------------------------------------------------------
// led_frame_crossfade_top
// Crossfade of an RGB LED strip from a snapshot frame to live effect frames.
// ----------------------------------------------------------------------------
// One item at a time. A pixel outside a transition goes from its transfer
// to ST_OUT and from there into the result register; the block then goes
// back to idle for the next transfer. A blended pixel first reads its
// snapshot entry (ST_RD, ST_SNAP), then runs each channel through the single
// mixer unit that handles red, green and blue in turn (hand-over, the
// multiply, eight divide steps, the add-back and the acknowledge), then
// ST_OUT, and the block again goes back to idle. A start request snapshots
// the shown frame with a copy sweep through the frame RAM read port. The
// result register lets the next item be taken while a result waits on
// m_tready.
module led_frame_crossfade_top
    import lfc_pkg::*;
#(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // slave stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // pixel_index, red_in, green_in, blue_in
    input  logic               s_tuser,   // req_type
    input  logic               s_tlast,   // frame_end
    // master stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // pixel_out_index, red_out, green_out, blue_out
    output logic               m_tuser,   // blending
    output logic               m_tlast,   // frame_last
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int CW = $clog2(NUM_PIXELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_COPY, ST_RD, ST_SNAP, ST_MIX, ST_WAIT, ST_OUT
    } state_t;

    typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} chan_t;

    // registers
    logic [STEP_W-1:0]     fade_steps_reg;
    logic [STEP_W-1:0]     fade_total_reg;
    logic [STEP_W-1:0]     frames_left_reg;
    state_t                state_reg;
    logic [NUM_PIXELS-1:0] shown_valid_reg;
    logic [NUM_PIXELS-1:0] start_valid_reg;
    logic [CW-1:0]         copy_cnt_reg;
    logic                  cp_pend_reg;
    logic [AW-1:0]         cp_addr_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [AW-1:0]         addr_reg;
    logic                  inside_reg;
    logic [PIX_W-1:0]      pix_reg;
    logic [PIX_W-1:0]      snap_reg;
    logic [PIX_W-1:0]      res_reg;
    logic                  last_reg;
    logic                  blend_reg;
    chan_t                 ch_reg;
    logic                  m_tvalid_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  m_tlast_reg;

    // input decode
    logic                  in_fire;
    logic [IDX_W-1:0]      in_idx;
    logic [PIX_W-1:0]      in_rgb;
    logic [AW+IDX_W-1:0]   in_idx_ext;
    logic [AW-1:0]         in_addr;
    logic                  in_inside;
    logic                  fading;
    logic                  out_free;
    logic                  out_load;
    logic                  copy_more;

    // RAM and mixer hookup
    logic                  shown_we;
    logic [PIX_W-1:0]      shown_rdata;
    logic                  start_we;
    logic [PIX_W-1:0]      start_rdata;
    mix_req_t              mix_req;
    logic                  mix_start;
    logic                  mix_ack;
    logic [CH_W-1:0]       mix_result;
    logic [CH_W-1:0]       from_ch;
    logic [CH_W-1:0]       to_ch;
    logic                  cfg_wr;

    assign in_fire    = s_tvalid && s_tready;
    assign in_idx     = s_tdata[IDX_W-1:0];
    // stored packing: red high, blue low
    assign in_rgb     = {s_tdata[12:5], s_tdata[20:13], s_tdata[28:21]};
    assign in_idx_ext = {{AW{1'b0}}, in_idx};
    assign in_addr    = in_idx_ext[AW-1:0];
    assign in_inside  = ({{(32-IDX_W){1'b0}}, in_idx} < 32'(NUM_PIXELS));
    assign fading     = (frames_left_reg != '0) && (fade_total_reg != '0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == ST_OUT) && out_free;
    assign copy_more  = (copy_cnt_reg < CW'(NUM_PIXELS));

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FADE_STEPS) ? {{(32-STEP_W){1'b0}}, fade_steps_reg}
                                                  : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_steps_reg <= FADE_RESET;
        end else if (cfg_wr && (paddr[2] == REG_FADE_STEPS)) begin
            fade_steps_reg <= pwdata[STEP_W-1:0];
        end
    end

    // channel select for the mixer
    always_comb begin
        case (ch_reg)
            CH_RED: begin
                from_ch = snap_reg[23:16];
                to_ch   = pix_reg[23:16];
            end
            CH_GREEN: begin
                from_ch = snap_reg[15:8];
                to_ch   = pix_reg[15:8];
            end
            default: begin
                from_ch = snap_reg[7:0];
                to_ch   = pix_reg[7:0];
            end
        endcase
    end

    assign mix_req.from_val  = from_ch;
    assign mix_req.to_val    = to_ch;
    assign mix_req.done_cnt  = fade_total_reg - frames_left_reg;
    assign mix_req.total_cnt = fade_total_reg;
    assign mix_start         = (state_reg == ST_MIX);

    assign shown_we = (state_reg == ST_OUT) && out_free && inside_reg;
    assign start_we = (state_reg == ST_COPY) && cp_pend_reg;

    lfc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (NUM_PIXELS),
        .AW    (AW)
    ) u_shown_ram (
        .aclk  (aclk),
        .we    (shown_we),
        .waddr (addr_reg),
        .wdata (res_reg),
        .raddr (copy_cnt_reg[AW-1:0]),
        .rdata (shown_rdata)
    );

    lfc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (NUM_PIXELS),
        .AW    (AW)
    ) u_start_ram (
        .aclk  (aclk),
        .we    (start_we),
        .waddr (cp_addr_reg),
        .wdata (shown_rdata),
        .raddr (addr_reg),
        .rdata (start_rdata)
    );

    lfc_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .req     (mix_req),
        .ack     (mix_ack),
        .result  (mix_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            shown_valid_reg <= '0;
            start_valid_reg <= '0;
            frames_left_reg <= '0;
            fade_total_reg  <= FADE_RESET;
            cp_pend_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_tuser == REQ_START) begin
                            fade_total_reg  <= fade_steps_reg;
                            frames_left_reg <= fade_steps_reg;
                            // never-written entries read as zero from the snapshot
                            start_valid_reg <= shown_valid_reg;
                            copy_cnt_reg    <= '0;
                            cp_pend_reg     <= 1'b0;
                            state_reg       <= ST_COPY;
                        end else begin
                            idx_reg    <= in_idx;
                            addr_reg   <= in_addr;
                            inside_reg <= in_inside;
                            pix_reg    <= in_rgb;
                            res_reg    <= in_rgb;
                            last_reg   <= s_tlast;
                            blend_reg  <= fading;
                            ch_reg     <= CH_RED;
                            state_reg  <= fading ? ST_RD : ST_OUT;
                        end
                    end
                end
                ST_COPY: begin
                    // read one entry a cycle, write it in the next
                    cp_addr_reg <= copy_cnt_reg[AW-1:0];
                    if (copy_more) begin
                        cp_pend_reg  <= 1'b1;
                        copy_cnt_reg <= copy_cnt_reg + CW'(1);
                    end else begin
                        cp_pend_reg <= 1'b0;
                        if (!cp_pend_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_SNAP;
                end
                ST_SNAP: begin
                    snap_reg  <= (inside_reg && start_valid_reg[addr_reg]) ? start_rdata
                                                                           : '0;
                    state_reg <= ST_MIX;
                end
                ST_MIX: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mix_ack) begin
                        case (ch_reg)
                            CH_RED:   res_reg[23:16] <= mix_result;
                            CH_GREEN: res_reg[15:8]  <= mix_result;
                            default:  res_reg[7:0]   <= mix_result;
                        endcase
                        if (ch_reg == CH_BLUE) begin
                            state_reg <= ST_OUT;
                        end else begin
                            ch_reg    <= (ch_reg == CH_RED) ? CH_GREEN : CH_BLUE;
                            state_reg <= ST_MIX;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {3'b000, res_reg[7:0], res_reg[15:8],
                                         res_reg[23:16], idx_reg};
                        m_tuser_reg  <= blend_reg;
                        m_tlast_reg  <= last_reg;
                        if (inside_reg) begin
                            shown_valid_reg[addr_reg] <= 1'b1;
                        end
                        if (last_reg && (frames_left_reg != '0)) begin
                            frames_left_reg <= frames_left_reg - STEP_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
